// ===== rtl/xcp_pkg.sv =====
// ----------------------------------------------------------------------------
// xcp_pkg
// Shared types, constants and the xorshift32 step for the pixel cipher.
// ----------------------------------------------------------------------------
package xcp_pkg;

  localparam int COUNT_WIDTH_DEF  = 24;
  localparam int PIXEL_COUNT_BITS = 24;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 32;
  localparam int PIX_W            = 24;
  localparam int CH_W             = 8;

  localparam int XS_SHL_A = 13;
  localparam int XS_SHR_B = 17;
  localparam int XS_SHL_C = 5;

  // register indices on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;  // reload generator from seed, latch frame-start word
    logic step;  // one skip step of the generator
    logic emit;  // produce a result word and advance the generator
    logic held;  // emit from the latched frame-start word
  } xcp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
  } xcp_stat_t;

  function automatic logic [31:0] xs_next(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << XS_SHL_A);
    t = t ^ (t >> XS_SHR_B);
    t = t ^ (t << XS_SHL_C);
    return t;
  endfunction

endpackage

// ===== rtl/xcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// xcp_ctrl
// Sequencer: accepts words, runs the frame-start skip, owns the output valid.
// ----------------------------------------------------------------------------
module xcp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_frame_start,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  xcp_pkg::xcp_stat_t stat,
  output xcp_pkg::xcp_cmd_t  cmd
);
  import xcp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SKIP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_frame_start) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SKIP;
          end else begin
            cmd.emit      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_SKIP: begin
        if (!stat.cnt_zero) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.held      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/xcp_dp.sv =====
// ----------------------------------------------------------------------------
// xcp_dp
// Datapath: configuration registers, generator, skip counter, chaining, output.
// ----------------------------------------------------------------------------
module xcp_dp #(
  parameter int COUNT_WIDTH = xcp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [xcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xcp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [xcp_pkg::CH_W-1:0]         in_red_in,
  input  logic [xcp_pkg::CH_W-1:0]         in_green_in,
  input  logic [xcp_pkg::CH_W-1:0]         in_blue_in,
  output logic [xcp_pkg::CH_W-1:0]         out_red_out,
  output logic [xcp_pkg::CH_W-1:0]         out_green_out,
  output logic [xcp_pkg::CH_W-1:0]         out_blue_out,
  input  xcp_pkg::xcp_cmd_t                cmd,
  output xcp_pkg::xcp_stat_t               stat
);
  import xcp_pkg::*;

  localparam int CNT_W = (COUNT_WIDTH < PIXEL_COUNT_BITS) ? COUNT_WIDTH : PIXEL_COUNT_BITS;

  logic [31:0]      key_seed_r, start_value_r;
  logic [CNT_W-1:0] pixel_count_r;
  logic             decrypt_mode_r;

  logic [31:0]      ks_r, ks_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PIX_W-1:0] prev_r, prev_nxt;
  logic [PIX_W-1:0] held_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [PIX_W-1:0] in_pix, pix_sel, mix, res;

  assign in_pix  = {in_red_in, in_green_in, in_blue_in};
  assign pix_sel = cmd.held ? held_r : in_pix;
  assign mix     = cmd.held ? start_value_r[PIX_W-1:0] : prev_r;
  assign res     = pix_sel ^ mix ^ ks_r[PIX_W-1:0];

  assign stat.cnt_zero = (cnt_r == '0);

  always_comb begin
    ks_nxt   = ks_r;
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    if (cmd.load) begin
      ks_nxt  = key_seed_r;
      cnt_nxt = pixel_count_r;
    end else if (cmd.step) begin
      ks_nxt  = xs_next(ks_r);
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd.emit) begin
      ks_nxt   = xs_next(ks_r);
      prev_nxt = decrypt_mode_r ? pix_sel : res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_seed_r     <= '0;
      start_value_r  <= '0;
      pixel_count_r  <= CNT_W'(1);
      decrypt_mode_r <= 1'b0;
      ks_r           <= '0;
      cnt_r          <= '0;
      prev_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_SEED:     key_seed_r     <= cfg_wdata;
          CFG_START_VALUE:  start_value_r  <= cfg_wdata;
          CFG_PIXEL_COUNT:  pixel_count_r  <= cfg_wdata[CNT_W-1:0];
          CFG_DECRYPT_MODE: decrypt_mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      ks_r   <= ks_nxt;
      cnt_r  <= cnt_nxt;
      prev_r <= prev_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_r <= in_pix;
    end
    if (cmd.emit) begin
      out_pix_r <= res;
    end
  end

  assign out_red_out   = out_pix_r[3*CH_W-1:2*CH_W];
  assign out_green_out = out_pix_r[2*CH_W-1:CH_W];
  assign out_blue_out  = out_pix_r[CH_W-1:0];

endmodule

// ===== rtl/xorshift_chained_xor_pixel_cipher.sv =====
// A chained word gives its result in the cycle after acceptance.
// A frame-start word reloads the generator from the seed, which is then walked
// one xorshift32 step per cycle through pixel_count steps; the held word is
// emitted once the output is free. Chained words are taken one word per cycle
// while the output is not stalled; a frame-start word blocks the input until emitted.
// Reset (rst_n low, synchronous): output empty, generator and chain zero.
// ----------------------------------------------------------------------------
// xorshift_chained_xor_pixel_cipher
// Chained-XOR RGB pixel cipher keyed by an xorshift32 keystream.
// ----------------------------------------------------------------------------
module xorshift_chained_xor_pixel_cipher #(
  parameter int COUNT_WIDTH = xcp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [xcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xcp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [xcp_pkg::CH_W-1:0]       in_red_in,
  input  logic [xcp_pkg::CH_W-1:0]       in_green_in,
  input  logic [xcp_pkg::CH_W-1:0]       in_blue_in,
  input  logic                           in_frame_start,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [xcp_pkg::CH_W-1:0]       out_red_out,
  output logic [xcp_pkg::CH_W-1:0]       out_green_out,
  output logic [xcp_pkg::CH_W-1:0]       out_blue_out
);
  import xcp_pkg::*;

  xcp_cmd_t  cmd;
  xcp_stat_t stat;

  // Sequencer: takes a chained word straight into the output register; on a
  // frame start it holds the input off, walks the skip, then emits the held word.
  xcp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Datapath: generator state, skip counter, previous cipher word and
  // the output register, plus the configuration bank.
  xcp_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

// ===== rtl/xcp_checker.sv =====
// ----------------------------------------------------------------------------
// xcp_checker
// Port-level checks on the pixel cipher, bound to the top level.
// ----------------------------------------------------------------------------
module xcp_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_frame_start,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [xcp_pkg::CH_W-1:0] out_red_out,
  input logic [xcp_pkg::CH_W-1:0] out_green_out,
  input logic [xcp_pkg::CH_W-1:0] out_blue_out
);
  import xcp_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out))
    else $error("stalled result word dropped or changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a chained word gives its result in the next cycle
  a_chain_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_frame_start |=> out_valid)
    else $error("chained word result missing");

  // a frame start blocks the input while the skip runs
  a_skip_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_start |=> !in_ready)
    else $error("input taken during frame-start skip");

endmodule

bind xorshift_chained_xor_pixel_cipher xcp_checker u_xcp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_frame_start (in_frame_start),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red_out    (out_red_out),
  .out_green_out  (out_green_out),
  .out_blue_out   (out_blue_out)
);
